@@ hw/rtl/dstp_pkg.sv @@
// Package for the dual stream timestamp pairer.
// Holds field widths, register and status codes, FSM states and the
// controller/datapath command and status structs. No dependencies.
package dstp_pkg;

    localparam int TIME_W = 48;
    localparam int SEQ_W = 32;
    localparam int WINDOW_W = 24;
    localparam int DROP_W = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TAG_BITS_DEF = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW   = 2'd0,
        CFG_COLOR_EN = 2'd1,
        CFG_DEPTH_EN = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED   = 3'd0,
        ST_PAIRED   = 3'd1,
        ST_STALE    = 3'd2,
        ST_BACKWARD = 3'd3,
        ST_DISABLED = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_DIFF,
        S_DECIDE,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    in_ready;
        logic    load_in;
        logic    set_last;
        logic    clear_last;
        logic    push_own;
        logic    clear_own;
        logic    pop_other;
        logic    drop_inc;
        logic    cap_cmp;
        logic    take_pair;
        logic    set_status;
        t_status status_code;
        logic    load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic enabled;
        logic seq_back;
        logic other_empty;
        logic own_full;
        logic front_ge;
        logic diff_lt_win;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/dstp_in_if.sv @@
// Frame event channel of the dual stream timestamp pairer.
// Depends on dstp_pkg for field widths.
interface dstp_in_if #(
    parameter int TAG_BITS = dstp_pkg::TAG_BITS_DEF
);
    import dstp_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [SEQ_W-1:0]    seq_number;
    logic [TIME_W-1:0]   stamp_us;
    logic [TIME_W-1:0]   arrival_us;
    logic [TAG_BITS-1:0] frame_tag;

    modport source (
        output valid, mode, seq_number, stamp_us, arrival_us, frame_tag,
        input  ready
    );
    modport sink (
        input  valid, mode, seq_number, stamp_us, arrival_us, frame_tag,
        output ready
    );
endinterface

@@ hw/rtl/dstp_out_if.sv @@
// Result channel of the dual stream timestamp pairer.
// Depends on dstp_pkg for field widths.
interface dstp_out_if #(
    parameter int TAG_BITS = dstp_pkg::TAG_BITS_DEF
);
    import dstp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   pair_time_us;
    logic [TAG_BITS-1:0] color_tag;
    logic [TAG_BITS-1:0] depth_tag;
    logic [DROP_W-1:0]   dropped_count;

    modport source (
        output valid, status, pair_time_us, color_tag, depth_tag, dropped_count,
        input  ready
    );
    modport sink (
        input  valid, status, pair_time_us, color_tag, depth_tag, dropped_count,
        output ready
    );
endinterface

@@ hw/rtl/dstp_cfg_if.sv @@
// Configuration write channel of the dual stream timestamp pairer.
// Depends on dstp_pkg for index and data widths.
interface dstp_cfg_if;
    import dstp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WINDOW_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dstp_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
module dstp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/dstp_ctrl.sv @@
// Sequencing FSM of the dual stream timestamp pairer.
// Depends on dstp_pkg (states, status codes, command/status structs).
module dstp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dstp_pkg::t_dp_sts i_sts,
    output dstp_pkg::t_dp_cmd o_cmd
);
    import dstp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd = '0;
        w_cmd.status_code = ST_QUEUED;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.enabled) begin
                    w_cmd.set_status = 1'b1;
                    w_cmd.status_code = ST_DISABLED;
                    n_state = S_FINISH;
                end else if (i_sts.seq_back) begin
                    w_cmd.clear_last = 1'b1;
                    w_cmd.set_status = 1'b1;
                    w_cmd.status_code = ST_BACKWARD;
                    n_state = S_FINISH;
                end else begin
                    w_cmd.set_last = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                // RAM reads the other queue's head this cycle
                if (i_sts.other_empty) begin
                    w_cmd.set_status = 1'b1;
                    if (i_sts.own_full) begin
                        w_cmd.status_code = ST_FULL;
                    end else begin
                        w_cmd.push_own = 1'b1;
                        w_cmd.status_code = ST_QUEUED;
                    end
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                w_cmd.cap_cmp = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.diff_lt_win) begin
                    w_cmd.take_pair = 1'b1;
                    w_cmd.pop_other = 1'b1;
                    w_cmd.clear_own = 1'b1;
                    w_cmd.set_status = 1'b1;
                    w_cmd.status_code = ST_PAIRED;
                    n_state = S_FINISH;
                end else if (i_sts.front_ge) begin
                    // other entry too far ahead: this frame is stale
                    w_cmd.clear_own = 1'b1;
                    w_cmd.set_status = 1'b1;
                    w_cmd.status_code = ST_STALE;
                    n_state = S_FINISH;
                end else begin
                    w_cmd.pop_other = 1'b1;
                    w_cmd.drop_inc = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;
endmodule

@@ hw/rtl/dstp_dp.sv @@
// Datapath of the dual stream timestamp pairer: config registers, frame
// registers, queue pointers, queue RAMs and the result register.
// Depends on dstp_pkg, dstp_in_if, dstp_out_if, dstp_cfg_if and dstp_ram.
module dstp_dp #(
    parameter int QUEUE_DEPTH = dstp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS = dstp_pkg::TAG_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dstp_in_if.sink           i_frame,
    dstp_out_if.source        o_result,
    dstp_cfg_if.sink          i_cfg,
    input  dstp_pkg::t_dp_cmd i_cmd,
    output dstp_pkg::t_dp_sts o_sts
);
    import dstp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TIME_W + TAG_BITS;

    // configuration
    logic [WINDOW_W-1:0] r_window;
    logic                r_en [2];

    // current frame
    logic                r_mode;
    logic [SEQ_W-1:0]    r_seq;
    logic [TIME_W-1:0]   r_now;
    logic [TAG_BITS-1:0] r_tag;

    // per stream state, index 0 color, 1 depth
    logic [SEQ_W-1:0]    r_last  [2];
    logic [AW-1:0]       r_head  [2];
    logic [CW-1:0]       r_count [2];
    logic [EW-1:0]       w_rdata [2];

    // compare stage
    logic                r_ge;
    logic [TIME_W-1:0]   r_diff;
    logic [TIME_W-1:0]   r_front_time;
    logic [TAG_BITS-1:0] r_front_tag;

    // working result
    t_status             r_status;
    logic [TIME_W-1:0]   r_pair_time;
    logic [TAG_BITS-1:0] r_ctag;
    logic [TAG_BITS-1:0] r_dtag;
    logic [DROP_W-1:0]   r_dropped;

    // result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [TIME_W-1:0]   r_out_time;
    logic [TAG_BITS-1:0] r_out_ctag;
    logic [TAG_BITS-1:0] r_out_dtag;
    logic [DROP_W-1:0]   r_out_dropped;

    logic                w_own;
    logic                w_oth;
    logic [EW-1:0]       w_front;
    logic [TIME_W-1:0]   w_front_time;
    logic [AW:0]         w_sum;
    logic [AW-1:0]       w_slot;
    logic [AW-1:0]       w_oth_head_nxt;
    logic                w_out_take;
    logic                w_in_take;

    assign w_own = r_mode;
    assign w_oth = ~r_mode;
    assign w_front = w_rdata[w_oth];
    assign w_front_time = w_front[TIME_W-1:0];
    assign w_in_take = i_frame.valid && i_cmd.in_ready;
    assign w_out_take = r_out_valid && o_result.ready;

    // slot after the own queue's tail; head + count stays below twice the depth
    assign w_sum = {1'b0, r_head[w_own]} + (AW+1)'(r_count[w_own]);
    assign w_slot = (w_sum >= (AW+1)'(QUEUE_DEPTH))
        ? AW'(w_sum - (AW+1)'(QUEUE_DEPTH)) : w_sum[AW-1:0];
    assign w_oth_head_nxt = (r_head[w_oth] == AW'(QUEUE_DEPTH - 1))
        ? '0 : r_head[w_oth] + AW'(1);

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_en[0] <= 1'b0;
            r_en[1] <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WINDOW:   r_window <= i_cfg.data;
                CFG_COLOR_EN: r_en[0] <= i_cfg.data[0];
                CFG_DEPTH_EN: r_en[1] <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // frame capture and compare stage
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_mode <= i_frame.mode;
            r_seq <= i_frame.seq_number;
            r_now <= (i_frame.stamp_us != '0) ? i_frame.stamp_us : i_frame.arrival_us;
            r_tag <= i_frame.frame_tag;
        end
        if (i_cmd.cap_cmp) begin
            r_ge <= w_front_time >= r_now;
            r_diff <= (w_front_time >= r_now) ? w_front_time - r_now
                                              : r_now - w_front_time;
            r_front_time <= w_front_time;
            r_front_tag <= w_front[EW-1:TIME_W];
        end
    end

    // sequence tracking and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                r_last[s] <= '0;
                r_head[s] <= '0;
                r_count[s] <= '0;
            end
        end else begin
            if (i_cmd.set_last) begin
                r_last[w_own] <= r_seq;
            end
            if (i_cmd.clear_last) begin
                r_last[w_own] <= '0;
            end
            if (i_cmd.pop_other) begin
                r_head[w_oth] <= w_oth_head_nxt;
                r_count[w_oth] <= r_count[w_oth] - CW'(1);
            end
            if (i_cmd.clear_own) begin
                r_head[w_own] <= '0;
                r_count[w_own] <= '0;
            end
            if (i_cmd.push_own) begin
                r_count[w_own] <= r_count[w_own] + CW'(1);
            end
        end
    end

    dstp_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram_color (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_own && !r_mode),
        .i_waddr (w_slot),
        .i_wdata ({r_tag, r_now}),
        .i_raddr (r_head[0]),
        .o_rdata (w_rdata[0])
    );

    dstp_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram_depth (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_own && r_mode),
        .i_waddr (w_slot),
        .i_wdata ({r_tag, r_now}),
        .i_raddr (r_head[1]),
        .o_rdata (w_rdata[1])
    );

    // working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_status <= ST_QUEUED;
            r_pair_time <= '0;
            r_ctag <= '0;
            r_dtag <= '0;
            r_dropped <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_code;
            end
            if (i_cmd.take_pair) begin
                r_pair_time <= r_ge ? r_front_time : r_now;
                r_ctag <= r_mode ? r_front_tag : r_tag;
                r_dtag <= r_mode ? r_tag : r_front_tag;
            end
            if (i_cmd.drop_inc && r_dropped != '1) begin
                r_dropped <= r_dropped + DROP_W'(1);
            end
        end
    end

    // result register, parts the work from a stalled receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_time <= r_pair_time;
            r_out_ctag <= r_ctag;
            r_out_dtag <= r_dtag;
            r_out_dropped <= r_dropped;
        end
    end

    assign i_frame.ready = i_cmd.in_ready;
    assign o_result.valid = r_out_valid;
    assign o_result.status = r_out_status;
    assign o_result.pair_time_us = r_out_time;
    assign o_result.color_tag = r_out_ctag;
    assign o_result.depth_tag = r_out_dtag;
    assign o_result.dropped_count = r_out_dropped;

    always_comb begin
        o_sts.in_valid = i_frame.valid;
        o_sts.enabled = r_en[w_own];
        o_sts.seq_back = r_seq < r_last[w_own];
        o_sts.other_empty = r_count[w_oth] == '0;
        o_sts.own_full = r_count[w_own] == CW'(QUEUE_DEPTH);
        o_sts.front_ge = r_ge;
        o_sts.diff_lt_win = r_diff < TIME_W'(r_window);
        o_sts.out_free = !r_out_valid || o_result.ready;
    end
endmodule

@@ hw/rtl/dual_stream_timestamp_pairer.sv @@
// Dual stream timestamp pairer, top level.
// Depends on dstp_pkg, the dstp_*_if interfaces, dstp_ctrl and dstp_dp.
//
// Usage: i_frame carries one frame event (color or depth) per beat. Each
// beat gives exactly one beat on o_result: queued, paired (with the later
// timestamp and both tags), stale, backward sequence, disabled or queue
// full, plus the count of stale entries dropped from the other queue.
// i_cfg writes the match window and the two stream enables; it is always
// ready. The user must write it only while no frame is in flight; the
// block itself does not enforce this.
// Timing: a frame is handled one at a time by a state machine that walks
// the other stream's queue one entry at a time (RAM read, compare,
// decide). A disabled or backward frame goes from the check straight to
// the result. i_frame.ready returns the cycle after the result is loaded.
// Reset clears pointers, counts, last sequences and the config registers
// (window 10000 us, both streams disabled); queue contents are not cleared.
// A stalled receiver holds the result register; the next frame is still
// taken and worked on, and only its result waits for the register.
module dual_stream_timestamp_pairer #(
    parameter int QUEUE_DEPTH = dstp_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS = dstp_pkg::TAG_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dstp_in_if.sink    i_frame,
    dstp_out_if.source o_result,
    dstp_cfg_if.sink   i_cfg
);
    import dstp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dstp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dstp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (i_frame),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

    // result register never overwritten while a beat is still pending
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("result loaded while output stalled");

    // one frame at a time
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame.valid && i_frame.ready) |=> !i_frame.ready)
        else $error("frame accepted while another is in flight");

    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push_own |-> (!w_sts.own_full && w_sts.other_empty))
        else $error("push into full queue or with other queue pending");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop_other |-> !w_sts.other_empty)
        else $error("pop from empty queue");
endmodule
